[rtl/skt_pkg.sv]
// shared types, constants and the id match helper for the session key table
package skt_pkg;

  localparam int ENTRIES = 16;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_READ   = 2'd1,
    OP_UPDATE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  // search or commit token handed from cell to cell
  typedef struct packed {
    logic        vld;
    logic        commit;
    logic        use_match;
    op_t         op;
    logic [63:0] client_id;
    logic [63:0] server_id;
    logic [7:0]  status_value;
    logic [63:0] key_word;
    logic        matched;
    logic        empty_seen;
    logic [7:0]  status_out;
    logic [63:0] key_out;
  } token_t;

  // keep bytes up to the first zero byte, zero everything after it
  function automatic logic [63:0] id_canon(input logic [63:0] v);
    logic [63:0] r;
    logic        live;
    r    = '0;
    live = 1'b1;
    for (int b = 0; b < 8; b++) begin
      if (v[8*b +: 8] == 8'd0) begin
        live = 1'b0;
      end
      if (live) begin
        r[8*b +: 8] = v[8*b +: 8];
      end
    end
    return r;
  endfunction

endpackage

[rtl/skt_cell.sv]
// one table entry with its compare logic and token stage
module skt_cell (
  input  logic           clk,
  input  logic           rst,
  input  skt_pkg::token_t tok_in,
  output skt_pkg::token_t tok_out
);
  import skt_pkg::*;

  logic [63:0] ent_client;
  logic [63:0] ent_server;
  logic [7:0]  ent_status;
  logic [63:0] ent_key;
  logic        mark_match;
  logic        mark_empty;

  logic   id_hit;
  logic   is_empty;
  logic   searching;
  logic   first_hit;
  logic   write_here;
  token_t tok_next;

  // compare the stored id pair and test for an all-zero entry
  assign id_hit   = (id_canon(ent_client) == id_canon(tok_in.client_id)) &&
                    (id_canon(ent_server) == id_canon(tok_in.server_id));
  assign is_empty = (ent_client == 64'd0) && (ent_server == 64'd0) &&
                    (ent_status == 8'd0) && (ent_key == 64'd0);
  assign searching  = tok_in.vld && !tok_in.commit;
  assign first_hit  = searching && !tok_in.matched && id_hit;
  assign write_here = tok_in.vld && tok_in.commit &&
                      (tok_in.use_match ? mark_match : mark_empty);

  // fold this entry into the passing token
  always_comb begin
    tok_next = tok_in;
    if (searching) begin
      tok_next.matched    = tok_in.matched | id_hit;
      tok_next.empty_seen = tok_in.empty_seen | is_empty;
      if (first_hit && tok_in.op == OP_READ) begin
        tok_next.status_out = ent_status;
        tok_next.key_out    = ent_key;
      end
    end
  end

  // entry storage, marks and the token stage
  always_ff @(posedge clk) begin
    if (rst) begin
      ent_client <= '0;
      ent_server <= '0;
      ent_status <= '0;
      ent_key    <= '0;
      mark_match <= 1'b0;
      mark_empty <= 1'b0;
      tok_out    <= '0;
    end else begin
      tok_out <= tok_next;
      if (searching) begin
        unique case (tok_in.op)
          OP_WRITE: begin
            mark_match <= first_hit;
            mark_empty <= !tok_in.empty_seen && is_empty;
          end
          OP_READ: begin
          end
          OP_UPDATE: begin
            if (first_hit) begin
              ent_status <= tok_in.status_value;
            end
          end
          OP_CLEAR: begin
            ent_client <= '0;
            ent_server <= '0;
            ent_status <= '0;
            ent_key    <= '0;
          end
        endcase
      end else if (write_here) begin
        ent_client <= tok_in.client_id;
        ent_server <= tok_in.server_id;
        ent_status <= tok_in.status_value;
        ent_key    <= tok_in.key_word;
      end
    end
  end

endmodule

[rtl/session_key_table_top.sv]
// session key table top level: sequencer, output register and the cell chain
//
//  channel | valid     | ready     | payload
//  --------+-----------+-----------+----------------------------------------------
//  in      | in_valid  | in_ready  | operation client_id server_id status_value key_word
//  out     | out_valid | out_ready | ok found status_out key_out
//
// a token walks the row of ENTRIES cells one cell a cycle; read, update and
// clear take one pass, a write takes a search pass and, if that found a match
// or an empty entry, a commit pass; the result is registered in the output register;
// a new item is taken only after the last result has been loaded into it
// synchronous reset clears all entries at once; no sweep is needed
// a new item is taken while a result waits; a stalled output holds the next
// result back in the sequencer until the output register frees
module session_key_table_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [63:0] client_id,
  input  logic [63:0] server_id,
  input  logic [7:0]  status_value,
  input  logic [63:0] key_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        ok,
  output logic        found,
  output logic [7:0]  status_out,
  output logic [63:0] key_out
);
  import skt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_COMMIT,
    S_FLUSH
  } state_t;

  state_t      state;
  token_t      head;
  token_t      head_next;
  token_t      fresh;
  token_t      tail;
  token_t      tok [ENTRIES+1];
  logic [ENTRIES:0] tok_vld_vec;

  logic        commit_start;
  logic        out_load;

  logic        res_ok;
  logic        res_found;
  logic [7:0]  res_status;
  logic [63:0] res_key;

  assign in_ready = (state == S_IDLE);
  assign tok[0]   = head;
  assign tail     = tok[ENTRIES];

  // a write search that found a match or an empty entry starts a commit pass
  assign commit_start = (state == S_SEARCH) && tail.vld && (tail.op == OP_WRITE) &&
                        (tail.matched || tail.empty_seen);
  assign out_load     = (state == S_FLUSH) && (!out_valid || out_ready);

  // token built from an accepted item
  always_comb begin
    fresh              = '0;
    fresh.vld          = 1'b1;
    fresh.op           = op_t'(operation);
    fresh.client_id    = client_id;
    fresh.server_id    = server_id;
    fresh.status_value = status_value;
    fresh.key_word     = key_word;
  end

  // next token at the head of the chain: a fresh item or a write commit pass
  always_comb begin
    head_next     = head;
    head_next.vld = 1'b0;
    if (state == S_IDLE && in_valid) begin
      head_next = fresh;
    end else if (commit_start) begin
      head_next           = tail;
      head_next.commit    = 1'b1;
      head_next.use_match = tail.matched;
    end
  end

  // row of entry cells
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    skt_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  for (genvar i = 0; i <= ENTRIES; i++) begin : g_vld
    assign tok_vld_vec[i] = tok[i].vld;
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      out_valid <= 1'b0;
    end else begin
      head <= head_next;
      if (out_load) begin
        out_valid  <= 1'b1;
        ok         <= res_ok;
        found      <= res_found;
        status_out <= res_status;
        key_out    <= res_key;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (tail.vld) begin
            state <= commit_start ? S_COMMIT : S_FLUSH;
            unique case (tail.op)
              OP_WRITE: begin
                res_ok     <= commit_start;
                res_found  <= tail.matched;
                res_status <= 8'd0;
                res_key    <= 64'd0;
              end
              OP_READ: begin
                res_ok     <= tail.matched;
                res_found  <= tail.matched;
                res_status <= tail.status_out;
                res_key    <= tail.key_out;
              end
              OP_UPDATE: begin
                res_ok     <= tail.matched;
                res_found  <= tail.matched;
                res_status <= 8'd0;
                res_key    <= 64'd0;
              end
              OP_CLEAR: begin
                res_ok     <= 1'b1;
                res_found  <= 1'b0;
                res_status <= 8'd0;
                res_key    <= 64'd0;
              end
            endcase
          end
        end
        S_COMMIT: begin
          if (tail.vld) begin
            state <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // never more than one token in the chain
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $countones(tok_vld_vec) <= 1)
    else $error("more than one token in the cell chain");

  // the chain is empty whenever a new item can be taken
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (tok_vld_vec == '0))
    else $error("token in flight while idle");

  // a token leaves the chain only while the sequencer waits for it
  a_tail_state: assert property (@(posedge clk) disable iff (rst)
    tail.vld |-> (state == S_SEARCH || state == S_COMMIT))
    else $error("token left the chain in an unexpected state");

  // a commit pass only follows a write search
  a_commit_write: assert property (@(posedge clk) disable iff (rst)
    (head.vld && head.commit) |-> (head.op == OP_WRITE && state == S_COMMIT))
    else $error("commit token for an operation other than write");
`endif

endmodule
